// ===== hw/rtl/smf_pkg.sv =====
// ----------------------------------------------------------------------------
// smf_pkg: shared types and constants of the six-axis motion filter
// Axis types, mode state, command codes and the 16-bit saturation helper.
// ----------------------------------------------------------------------------
package smf_pkg;

  // Number of axes in one sample: translate x, y, z, then rotate x, y, z.
  localparam int AXES      = 6;
  localparam int AXIS_W    = 16;
  // Widest scaled value: a 16-bit axis times 64 needs 22 signed bits.
  localparam int SCALE_W   = 22;
  localparam int LEVEL_W   = 4;
  localparam int IDX_W     = 3;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  typedef logic signed [AXIS_W-1:0]  axis_t;
  typedef logic signed [SCALE_W-1:0] scaled_t;
  typedef logic [SCALE_W-1:0]        mag_t;
  typedef logic [LEVEL_W-1:0]        level_t;

  // Sensitivity limits; the middle level is the unity ratio.
  localparam level_t SENS_MAX = 4'd12;
  localparam level_t SENS_MID = 4'd6;

  // Saturation limits.
  localparam axis_t SAT_HI = 16'sh7FFF;
  localparam axis_t SAT_LO = 16'sh8000;

  // Request kinds.
  localparam logic OP_MOTION = 1'b0;
  localparam logic OP_MODE   = 1'b1;

  // Mode command codes.
  localparam logic [2:0] MODE_TRANS_TOGGLE = 3'd0;
  localparam logic [2:0] MODE_ROT_TOGGLE   = 3'd1;
  localparam logic [2:0] MODE_DOM_TOGGLE   = 3'd2;
  localparam logic [2:0] MODE_SENS_UP      = 3'd3;
  localparam logic [2:0] MODE_SENS_DOWN    = 3'd4;

  // Register index of the delivery enable.
  localparam logic REG_DELIVERY = 1'b0;

  // Filter mode state shared by the lanes and the merge stage.
  typedef struct packed {
    logic   translation_on;
    logic   rotation_on;
    logic   dominant_on;
    level_t level;
  } smf_mode_t;

  // Clamp a scaled value to the 16-bit signed range.
  function automatic axis_t sat16(input scaled_t v);
    axis_t r;
    if (v > scaled_t'(SAT_HI)) begin
      r = SAT_HI;
    end else if (v < scaled_t'(SAT_LO)) begin
      r = SAT_LO;
    end else begin
      r = v[AXIS_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/smf_if.sv =====
// ----------------------------------------------------------------------------
// smf_if: request and result channels of the motion filter
// Valid/ready channels; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------

// Input channel: mode commands and motion samples.
interface smf_in_if;
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [2:0]          mode_code;
  logic                apply_filter;
  logic signed [15:0]  translate_x;
  logic signed [15:0]  translate_y;
  logic signed [15:0]  translate_z;
  logic signed [15:0]  rotate_x;
  logic signed [15:0]  rotate_y;
  logic signed [15:0]  rotate_z;

  modport source (
    output valid, opcode, mode_code, apply_filter,
    output translate_x, translate_y, translate_z, rotate_x, rotate_y, rotate_z,
    input  ready
  );

  modport sink (
    input  valid, opcode, mode_code, apply_filter,
    input  translate_x, translate_y, translate_z, rotate_x, rotate_y, rotate_z,
    output ready
  );
endinterface

// Result channel: filtered motion samples.
interface smf_out_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  out_translate_x;
  logic signed [15:0]  out_translate_y;
  logic signed [15:0]  out_translate_z;
  logic signed [15:0]  out_rotate_x;
  logic signed [15:0]  out_rotate_y;
  logic signed [15:0]  out_rotate_z;

  modport source (
    output valid, out_translate_x, out_translate_y, out_translate_z,
    output out_rotate_x, out_rotate_y, out_rotate_z,
    input  ready
  );

  modport sink (
    input  valid, out_translate_x, out_translate_y, out_translate_z,
    input  out_rotate_x, out_rotate_y, out_rotate_z,
    output ready
  );
endinterface

// ===== hw/rtl/smf_lane.sv =====
// ----------------------------------------------------------------------------
// smf_lane: per-axis scaling lane
// Scales one axis by the sensitivity ratio, zeroes it when its group is
// locked, and reports its magnitude for the dominant-axis search.
// ----------------------------------------------------------------------------
module smf_lane (
  input  smf_pkg::axis_t     raw,
  input  smf_pkg::smf_mode_t mode,
  input  logic               is_rotation,
  output smf_pkg::scaled_t   scaled,
  output smf_pkg::mag_t      mag
);
  import smf_pkg::*;

  logic    up;
  logic [2:0] k;
  logic    group_on;
  scaled_t ext;
  mag_t    mask;
  scaled_t bias;
  scaled_t div_val;
  scaled_t mul_val;
  scaled_t val;

  // Shift direction and distance from the unity level.
  always_comb begin
    up = (mode.level > SENS_MID);
    if (up) begin
      k = 3'(mode.level - SENS_MID);
    end else begin
      k = 3'(SENS_MID - mode.level);
    end
  end

  // Power-of-two scaling; the bias makes the right shift truncate toward zero.
  always_comb begin
    ext     = scaled_t'(raw);
    mask    = (mag_t'(1) << k) - mag_t'(1);
    bias    = ext[SCALE_W-1] ? $signed(mask) : '0;
    div_val = (ext + bias) >>> k;
    mul_val = ext <<< k;
    val     = up ? mul_val : div_val;
  end

  // Group lock and magnitude.
  always_comb begin
    group_on = is_rotation ? mode.rotation_on : mode.translation_on;
    scaled   = group_on ? val : '0;
    mag      = scaled[SCALE_W-1] ? mag_t'(-scaled) : mag_t'(scaled);
  end

endmodule

// ===== hw/rtl/smf_merge.sv =====
// ----------------------------------------------------------------------------
// smf_merge: dominant-axis selection and saturation
// Combines the six lanes: finds the largest magnitude, keeps only that axis
// in dominant mode, saturates, or passes the raw sample through.
// ----------------------------------------------------------------------------
module smf_merge (
  input  smf_pkg::axis_t     raw    [smf_pkg::AXES],
  input  smf_pkg::scaled_t   scaled [smf_pkg::AXES],
  input  smf_pkg::mag_t      mag    [smf_pkg::AXES],
  input  smf_pkg::smf_mode_t mode,
  input  logic               apply_filter,
  output smf_pkg::axis_t     result [smf_pkg::AXES]
);
  import smf_pkg::*;

  logic [IDX_W-1:0] best;
  mag_t             best_mag;
  logic             keep;

  // Scan for the largest magnitude; strict compare lets the lowest index win ties.
  always_comb begin
    best     = '0;
    best_mag = mag[0];
    for (int i = 1; i < AXES; i++) begin
      if (mag[i] > best_mag) begin
        best     = IDX_W'(i);
        best_mag = mag[i];
      end
    end
  end

  // Output select per axis.
  always_comb begin
    keep = 1'b0;
    for (int i = 0; i < AXES; i++) begin
      keep = !mode.dominant_on || (best == IDX_W'(i));
      if (!apply_filter) begin
        result[i] = raw[i];
      end else if (keep) begin
        result[i] = sat16(scaled[i]);
      end else begin
        result[i] = '0;
      end
    end
  end

endmodule

// ===== hw/rtl/six_axis_motion_filter.sv =====
// ----------------------------------------------------------------------------
// six_axis_motion_filter: six-axis 3D mouse motion filter
// Applies mode commands to the filter state and turns motion samples into
// scaled, locked, dominant-filtered and saturated results.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake          Moves
// in_if     in         valid / ready      mode command or motion sample
// out_if    out        valid / ready      filtered motion sample
// cfg_*     in         APB write / read   delivery_enabled at byte address 0
//
// A request is taken every cycle unless a held result stalls; a delivered motion
// sample's result appears in the next cycle from the single output register behind the six lanes and merge.
// Reset (synchronous, rst_n low) sets translation and rotation on, dominant
// off, sensitivity level 6 and delivery disabled.
// A stalled result is held in the output register; a new request is taken
// in the same cycle that the held result is taken.
//
module six_axis_motion_filter (
  input  logic                          clk,
  input  logic                          rst_n,
  smf_in_if.sink                        in_if,
  smf_out_if.source                     out_if,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [smf_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [smf_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [smf_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);
  import smf_pkg::*;

  logic      delivery_r;
  logic      delivery_nxt;
  smf_mode_t mode_r;
  smf_mode_t mode_nxt;
  logic      out_valid_r;
  logic      out_valid_nxt;
  axis_t     out_axes_r   [AXES];
  axis_t     raw          [AXES];
  scaled_t   scaled       [AXES];
  mag_t      mag          [AXES];
  axis_t     result       [AXES];
  logic      in_accept;
  logic      load_result;
  logic      cfg_wr;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2] == REG_DELIVERY);
  assign cfg_prdata = (cfg_paddr[2] == REG_DELIVERY) ?
                      {{(CFG_DW-1){1'b0}}, delivery_r} : '0;
  assign delivery_nxt = cfg_wr ? cfg_pwdata[0] : delivery_r;

  // Handshake.
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_accept   = in_if.valid && in_if.ready;
  assign load_result = in_accept && (in_if.opcode == OP_MOTION) && delivery_r;

  // Mode command decode.
  always_comb begin
    mode_nxt = mode_r;
    if (in_accept && (in_if.opcode == OP_MODE)) begin
      unique case (in_if.mode_code)
        MODE_TRANS_TOGGLE: begin
          mode_nxt.translation_on = !mode_r.translation_on;
          if (mode_r.translation_on && !mode_r.rotation_on) begin
            mode_nxt.rotation_on = 1'b1;
          end
        end
        MODE_ROT_TOGGLE: begin
          mode_nxt.rotation_on = !mode_r.rotation_on;
          if (mode_r.rotation_on && !mode_r.translation_on) begin
            mode_nxt.translation_on = 1'b1;
          end
        end
        MODE_DOM_TOGGLE: begin
          mode_nxt.dominant_on = !mode_r.dominant_on;
        end
        MODE_SENS_UP: begin
          if (mode_r.level < SENS_MAX) begin
            mode_nxt.level = mode_r.level + level_t'(1);
          end
        end
        MODE_SENS_DOWN: begin
          if (mode_r.level != '0) begin
            mode_nxt.level = mode_r.level - level_t'(1);
          end
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end
  end

  // Six scaling lanes.
  assign raw[0] = in_if.translate_x;
  assign raw[1] = in_if.translate_y;
  assign raw[2] = in_if.translate_z;
  assign raw[3] = in_if.rotate_x;
  assign raw[4] = in_if.rotate_y;
  assign raw[5] = in_if.rotate_z;

  for (genvar g = 0; g < AXES; g++) begin : g_lane
    smf_lane u_lane (
      .raw         (raw[g]),
      .mode        (mode_r),
      .is_rotation (g >= (AXES / 2)),
      .scaled      (scaled[g]),
      .mag         (mag[g])
    );
  end

  // Merge stage.
  smf_merge u_merge (
    .raw          (raw),
    .scaled       (scaled),
    .mag          (mag),
    .mode         (mode_r),
    .apply_filter (in_if.apply_filter),
    .result       (result)
  );

  // Output register valid.
  always_comb begin
    if (load_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delivery_r            <= 1'b0;
      mode_r.translation_on <= 1'b1;
      mode_r.rotation_on    <= 1'b1;
      mode_r.dominant_on    <= 1'b0;
      mode_r.level          <= SENS_MID;
      out_valid_r           <= 1'b0;
    end else begin
      delivery_r  <= delivery_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load_result) begin
      out_axes_r <= result;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.out_translate_x = out_axes_r[0];
  assign out_if.out_translate_y = out_axes_r[1];
  assign out_if.out_translate_z = out_axes_r[2];
  assign out_if.out_rotate_x    = out_axes_r[3];
  assign out_if.out_rotate_y    = out_axes_r[4];
  assign out_if.out_rotate_z    = out_axes_r[5];

  // The sensitivity level never leaves its range.
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r.level <= SENS_MAX)
    else $error("sensitivity level out of range");

  // Translation and rotation are never both locked.
  a_group_on: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r.translation_on || mode_r.rotation_on)
    else $error("both axis groups disabled");

  // A delivered motion sample shows up as a result in the next cycle.
  a_motion_result: assert property (@(posedge clk) disable iff (!rst_n)
    load_result |=> out_valid_r)
    else $error("motion sample lost");

  // A request that makes no result leaves an empty output register empty.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !load_result && !out_valid_r) |=> !out_valid_r)
    else $error("result without a delivered motion sample");

endmodule
